@@ src/bmhq_pkg.sv @@
// Package for the binary max-heap queue: sizes, operation codes, sequencer
// states and the structs passed between the sequencer, compare unit and RAM.
// No dependencies.
package bmhq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  localparam val_t EMPTY_TOP = val_t'(-1);

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_INSERT  = 2'd2,
    OP_EXTRACT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EX_RD,
    S_EX_WT,
    S_BLD_RD,
    S_BLD_WT,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DN_END,
    S_UP_RD,
    S_UP_C,
    S_FIN_RD,
    S_FIN
  } state_e;

  // Value tagged with the heap index it came from
  typedef struct packed {
    val_t val;
    cnt_t idx;
  } node_t;

  typedef struct packed {
    logic  gt;   // b strictly greater than a
    node_t win;  // b when strictly greater, else a
  } cmp_res_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    val_t  wdata;
    addr_t raddr;
  } ram_req_t;

endpackage

@@ src/bmhq_if.sv @@
// Valid/ready channel interfaces for the heap queue items.
// Depends on bmhq_pkg.
interface bmhq_in_if;
  import bmhq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  val_t       value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bmhq_out_if;
  import bmhq_pkg::*;
  logic valid;
  logic ready;
  val_t top_value;
  cnt_t count;
  logic empty_res;
  logic overflow;

  modport source (output valid, output top_value, output count, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input top_value, input count, input empty_res,
                  input overflow, output ready);
endinterface

@@ src/binary_max_heap_queue.sv @@
// Binary max-heap priority queue of signed 32-bit values, top level.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram, bmhq_cmp and bmhq_ctrl.
//
// Usage:
//   in_i carries one item: kind (append, build, insert, extract) and value.
//   out_o returns one result per item: top value (-1 when empty), count,
//   empty flag and overflow flag (append or insert dropped when full).
//   The block takes one item at a time; in_i.ready is high only while idle.
// Each item is worked in steps set by the single RAM read port and the shared
// comparator: append, a dropped item, an empty extract or a short build go
// straight to the final read of the root; insert climbs one level per compare;
// extract moves the last value to the root and sinks it, reading the left and
// then the right child at each level; build sinks each node count/2..1 in turn.
// The sequencer returns to idle after each result before it takes the next item.
// The result sits in an output register; the next item is accepted while it
// waits, but that item's result holds in the sequencer until out_o.ready.
// Reset clears the fill count, so the heap starts empty; store contents
// are not cleared and are never read before being written.
module binary_max_heap_queue
  import bmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);

  ram_req_t ram_req;
  val_t     ram_rdata;
  node_t    cmp_a;
  node_t    cmp_b;
  cmp_res_t cmp_res;

  // Heap store
  bmhq_ram #(
    .Width (VAL_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compare-and-select unit
  bmhq_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // Sequencer
  bmhq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .ram_o   (ram_req),
    .rdata_i (ram_rdata),
    .cmp_a_o (cmp_a),
    .cmp_b_o (cmp_b),
    .cmp_i   (cmp_res)
  );

endmodule

@@ src/bmhq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmhq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/bmhq_cmp.sv @@
// Shared signed compare-and-select unit for sift-up and sift-down steps.
// Depends on bmhq_pkg.
module bmhq_cmp
  import bmhq_pkg::*;
(
  input  node_t    a_i,
  input  node_t    b_i,
  output cmp_res_t res_o
);

  // Take b only when strictly greater, so ties keep a
  always_comb begin
    res_o.gt  = (b_i.val > a_i.val);
    res_o.win = res_o.gt ? b_i : a_i;
  end

endmodule

@@ src/bmhq_ctrl.sv @@
// Heap sequencer: operation dispatch, sift-up and sift-down walks, fill count
// and output register. Depends on bmhq_pkg and bmhq_if; drives bmhq_ram and bmhq_cmp.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  bmhq_in_if.sink        in_i,
  bmhq_out_if.source     out_o,
  output ram_req_t       ram_o,
  input  val_t           rdata_i,
  output node_t          cmp_a_o,
  output node_t          cmp_b_o,
  input  cmp_res_t       cmp_i
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  val_t   val_q, val_d;
  cnt_t   count_q, count_d;
  cnt_t   idx_q, idx_d;
  cnt_t   bi_q, bi_d;
  val_t   cur_q, cur_d;
  node_t  best_q, best_d;
  logic   ovf_q, ovf_d;

  logic   out_valid_q, out_valid_d;
  val_t   top_q, top_d;
  cnt_t   cnt_out_q, cnt_out_d;
  logic   empty_q, empty_d;
  logic   ovf_out_q, ovf_out_d;

  logic [CNT_W:0] l_idx;
  logic [CNT_W:0] r_idx;
  cnt_t           parent;
  logic           l_beyond;
  logic           r_beyond;
  node_t          dn_win;
  logic           dn_stay;
  logic           out_free;

  // Walk indices and decisions
  assign l_idx    = {idx_q, 1'b0};
  assign r_idx    = {idx_q, 1'b1};
  assign parent   = idx_q >> 1;
  assign l_beyond = l_idx > {1'b0, count_q};
  assign r_beyond = r_idx > {1'b0, count_q};
  assign dn_win   = r_beyond ? best_q : cmp_i.win;
  assign dn_stay  = (dn_win.idx == idx_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = top_q;
  assign out_o.count     = cnt_out_q;
  assign out_o.empty_res = empty_q;
  assign out_o.overflow  = ovf_out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op_q)
          OP_APPEND:  state_d = S_FIN_RD;
          OP_INSERT:  state_d = (count_q == cnt_t'(CAPACITY)) ? S_FIN_RD : S_UP_RD;
          OP_BUILD:   state_d = ((count_q >> 1) == '0) ? S_FIN_RD : S_BLD_RD;
          OP_EXTRACT: state_d = (count_q == '0) ? S_FIN_RD : S_EX_RD;
          default:    state_d = S_FIN_RD;
        endcase
      end
      S_EX_RD:  state_d = S_EX_WT;
      S_EX_WT:  state_d = (count_q == cnt_t'(1)) ? S_FIN_RD : S_DN_L;
      S_BLD_RD: state_d = S_BLD_WT;
      S_BLD_WT: state_d = S_DN_L;
      S_DN_L:   state_d = l_beyond ? S_DN_END : S_DN_R;
      S_DN_R:   state_d = S_DN_C;
      S_DN_C:   state_d = dn_stay ? S_DN_END : S_DN_L;
      S_DN_END: state_d = (op_q == OP_BUILD && bi_q > cnt_t'(1)) ? S_BLD_RD : S_FIN_RD;
      S_UP_RD:  state_d = (idx_q == cnt_t'(1)) ? S_FIN_RD : S_UP_C;
      S_UP_C:   state_d = cmp_i.gt ? S_UP_RD : S_FIN_RD;
      S_FIN_RD: state_d = S_FIN;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM and compare unit control
  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    bi_d        = bi_q;
    cur_d       = cur_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    top_d       = top_q;
    cnt_out_d   = cnt_out_q;
    empty_d     = empty_q;
    ovf_out_d   = ovf_out_q;
    ram_o       = '{we: 1'b0, waddr: '0, wdata: cur_q, raddr: '0};
    cmp_a_o     = best_q;
    cmp_b_o     = '{val: rdata_i, idx: cnt_t'(r_idx)};

    case (state_q)
      S_IDLE: begin
        // Latch the item
        if (in_i.valid) begin
          op_d  = op_e'(in_i.kind);
          val_d = in_i.value;
          ovf_d = 1'b0;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          OP_APPEND, OP_INSERT: begin
            if (count_q == cnt_t'(CAPACITY)) begin
              ovf_d = 1'b1;
            end else begin
              // Place at the end; insert then sifts it up
              ram_o.we    = 1'b1;
              ram_o.waddr = addr_t'(count_q);
              ram_o.wdata = val_q;
              count_d     = count_q + cnt_t'(1);
              idx_d       = count_q + cnt_t'(1);
              cur_d       = val_q;
            end
          end
          OP_BUILD: begin
            bi_d = count_q >> 1;
          end
          default: begin
          end
        endcase
      end
      S_EX_RD: begin
        ram_o.raddr = addr_t'(count_q - cnt_t'(1));
      end
      S_EX_WT: begin
        // Last value becomes the sinking value at the root
        cur_d   = rdata_i;
        count_d = count_q - cnt_t'(1);
        idx_d   = cnt_t'(1);
      end
      S_BLD_RD: begin
        ram_o.raddr = addr_t'(bi_q - cnt_t'(1));
      end
      S_BLD_WT: begin
        cur_d = rdata_i;
        idx_d = bi_q;
      end
      S_DN_L: begin
        if (l_beyond) begin
          // Leaf reached: drop the sinking value into the hole
          ram_o.we    = 1'b1;
          ram_o.waddr = addr_t'(idx_q - cnt_t'(1));
          ram_o.wdata = cur_q;
        end else begin
          ram_o.raddr = addr_t'(l_idx - (CNT_W + 1)'(1));
        end
      end
      S_DN_R: begin
        // Left child against the sinking value
        ram_o.raddr = addr_t'(l_idx);
        cmp_a_o     = '{val: cur_q, idx: idx_q};
        cmp_b_o     = '{val: rdata_i, idx: cnt_t'(l_idx)};
        best_d      = cmp_i.win;
      end
      S_DN_C: begin
        // Right child against the best so far, then move or settle
        ram_o.we    = 1'b1;
        ram_o.waddr = addr_t'(idx_q - cnt_t'(1));
        if (dn_stay) begin
          ram_o.wdata = cur_q;
        end else begin
          ram_o.wdata = dn_win.val;
          idx_d       = dn_win.idx;
        end
      end
      S_DN_END: begin
        if (op_q == OP_BUILD) begin
          bi_d = bi_q - cnt_t'(1);
        end
      end
      S_UP_RD: begin
        if (idx_q == cnt_t'(1)) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = '0;
          ram_o.wdata = cur_q;
        end else begin
          ram_o.raddr = addr_t'(parent - cnt_t'(1));
        end
      end
      S_UP_C: begin
        // Rising value against its parent
        cmp_a_o     = '{val: rdata_i, idx: parent};
        cmp_b_o     = '{val: cur_q, idx: idx_q};
        ram_o.we    = 1'b1;
        ram_o.waddr = addr_t'(idx_q - cnt_t'(1));
        if (cmp_i.gt) begin
          ram_o.wdata = rdata_i;
          idx_d       = parent;
        end else begin
          ram_o.wdata = cur_q;
        end
      end
      S_FIN_RD: begin
        ram_o.raddr = '0;
      end
      S_FIN: begin
        // Load the result once the output register is free
        ram_o.raddr = '0;
        if (out_free) begin
          out_valid_d = 1'b1;
          top_d       = (count_q == '0) ? EMPTY_TOP : rdata_i;
          cnt_out_d   = count_q;
          empty_d     = (count_q == '0);
          ovf_out_d   = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    bi_q      <= bi_d;
    cur_q     <= cur_d;
    best_q    <= best_d;
    ovf_q     <= ovf_d;
    top_q     <= top_d;
    cnt_out_q <= cnt_out_d;
    empty_q   <= empty_d;
    ovf_out_q <= ovf_out_d;
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for binary_max_heap_queue: drives append, build, insert
// and extract items and checks every result against a behavioural heap.
// Depends on bmhq_pkg, bmhq_if and the RTL under src.
module testbench;
  import bmhq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no item moving on either side before the run is abandoned;
  // the limit must cover a build over a full store, during which no item moves.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 60;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    val_t top_value;
    cnt_t count;
    logic empty_res;
    logic overflow;
  } heap_status_t;

  // Behavioural heap plus the queue of statuses still owed by the block
  class heap_scoreboard;
    val_t         heap_mem[CAPACITY+1];
    int unsigned  fill;
    heap_status_t status_due[$];
    int unsigned  errors;
    int unsigned  n_items;
    int unsigned  n_checked;
    int unsigned  n_dropped;
    int unsigned  peak_fill;
    int unsigned  op_seen[4];

    function void swap_nodes(int unsigned a, int unsigned b);
      val_t t;
      t = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    // Sink a node while a child is strictly greater; left wins ties
    function void sink_from(int unsigned i);
      int unsigned l, r, best;
      while (i >= 1 && i <= fill) begin
        l = 2 * i;
        r = l + 1;
        best = i;
        if (l <= fill && heap_mem[l] > heap_mem[best]) best = l;
        if (r <= fill && heap_mem[r] > heap_mem[best]) best = r;
        if (best == i) break;
        swap_nodes(i, best);
        i = best;
      end
    endfunction

    // Climb while strictly greater than the parent
    function void climb_from(int unsigned i);
      while (i > 1 && i <= fill && heap_mem[i] > heap_mem[i/2]) begin
        swap_nodes(i, i / 2);
        i = i / 2;
      end
    endfunction

    // Apply one accepted item and queue the status it must produce
    function void note_item(op_e op, val_t v);
      heap_status_t st;
      logic         dropped;
      dropped = 1'b0;
      case (op)
        OP_APPEND, OP_INSERT: begin
          if (fill >= CAPACITY) begin
            dropped = 1'b1;
          end else begin
            fill++;
            heap_mem[fill] = v;
            if (op == OP_INSERT) climb_from(fill);
          end
        end
        OP_BUILD: begin
          for (int i = fill / 2; i >= 1; i--) sink_from(i);
        end
        default: begin
          if (fill > 0) begin
            heap_mem[1] = heap_mem[fill];
            fill--;
            if (fill > 0) sink_from(1);
          end
        end
      endcase
      st.top_value = (fill > 0) ? heap_mem[1] : EMPTY_TOP;
      st.count     = cnt_t'(fill);
      st.empty_res = (fill == 0);
      st.overflow  = dropped;
      status_due = {status_due, st};
      n_items++;
      op_seen[op]++;
      if (dropped) n_dropped++;
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    // Compare one accepted result with the oldest owed status
    function void check_result(val_t top, cnt_t cnt, logic emp, logic ovf);
      heap_status_t want;
      if (status_due.size() == 0) begin
        $error("unexpected result: top_value %0d count %0d", top, cnt);
        errors++;
        return;
      end
      want = status_due.pop_front();
      n_checked++;
      if (top !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, top);
        errors++;
      end
      if (cnt !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, cnt);
        errors++;
      end
      if (emp !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, emp);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  heap_scoreboard board = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  binary_max_heap_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Accept results, then pick ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_result(out_ch.top_value, out_ch.count, out_ch.empty_res,
                           out_ch.overflow);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count edges at which no item moves
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
      default:       begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Offer one item, idling first at random; valid stays high across items
  task automatic send_item(op_e op, val_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= op;
    in_ch.value <= v;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    board.note_item(op, v);
  endtask

  // Mix extremes, a narrow band that forces ties, and full-range values
  function automatic val_t rand_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0:       return val_t'(32'h8000_0000);
        1:       return val_t'(32'h7fff_ffff);
        2:       return EMPTY_TOP;
        default: return '0;
      endcase
    end
    if (pick <= 4) return val_t'(int'($urandom_range(15)) - 8);
    return val_t'($urandom());
  endfunction

  // Load raw values then heapify them
  task automatic raw_load(int unsigned n);
    repeat (n) send_item(OP_APPEND, rand_value());
    send_item(OP_BUILD, rand_value());
  endtask

  // Random operations over a small heap
  task automatic mixed_traffic(int unsigned n);
    int unsigned target;
    int unsigned pick;
    target = board.n_items + n;
    while (board.n_items < target) begin
      pick = $urandom_range(99);
      if (board.fill > 40 && pick < 50) pick = 60;
      if (pick < 8)       raw_load($urandom_range(2, 10));
      else if (pick < 50) send_item(OP_INSERT, rand_value());
      else if (pick < 80) send_item(OP_EXTRACT, rand_value());
      else if (pick < 90) send_item(OP_APPEND, rand_value());
      else                send_item(OP_BUILD, rand_value());
    end
  endtask

  initial begin
    int unsigned filled;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = OP_APPEND;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty heap, single value, extremes, ties, raw load and build
    send_item(OP_EXTRACT, val_t'(32'h1234_5678));
    send_item(OP_BUILD, '0);
    send_item(OP_APPEND, val_t'(5));
    send_item(OP_BUILD, '0);
    send_item(OP_EXTRACT, '0);
    send_item(OP_INSERT, val_t'(32'h7fff_ffff));
    send_item(OP_INSERT, val_t'(32'h8000_0000));
    send_item(OP_INSERT, EMPTY_TOP);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, val_t'(32'h7fff_ffff));
    send_item(OP_EXTRACT, '0);
    send_item(OP_EXTRACT, '0);
    send_item(OP_APPEND, EMPTY_TOP);
    send_item(OP_APPEND, val_t'(32'h8000_0000));
    send_item(OP_APPEND, val_t'(32'h7fff_ffff));
    send_item(OP_APPEND, val_t'(3));
    send_item(OP_APPEND, val_t'(3));
    send_item(OP_BUILD, '0);
    send_item(OP_EXTRACT, '0);
    send_item(OP_EXTRACT, '0);
    send_item(OP_EXTRACT, '0);
    send_item(OP_INSERT, val_t'(3));
    send_item(OP_INSERT, val_t'(3));

    // Random traffic over small heaps, rotating the idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      mixed_traffic(30);
    end

    // Hold the receiver off while items keep coming so the input stalls
    set_idling(IDLE_NONE);
    hold_req = 1'b1;
    mixed_traffic(24);

    // Fill the store to capacity, changing idling every 128 items
    filled = 0;
    while (board.fill < CAPACITY) begin
      if (filled % 128 == 0) set_idling(idle_mode_e'((filled / 128) % 4));
      send_item(($urandom_range(1) != 0) ? OP_INSERT : OP_APPEND, rand_value());
      filled++;
    end

    // Full store: drop, heapify, take some out, refill and drop again
    set_idling(IDLE_BOTH);
    send_item(OP_APPEND, rand_value());
    send_item(OP_INSERT, rand_value());
    send_item(OP_BUILD, '0);
    repeat (10) send_item(OP_EXTRACT, '0);
    while (board.fill < CAPACITY) send_item(OP_INSERT, rand_value());
    send_item(OP_INSERT, val_t'(32'h7fff_ffff));
    send_item(OP_APPEND, val_t'(32'h8000_0000));
    set_idling(IDLE_RECEIVER);
    repeat (40) send_item(OP_EXTRACT, '0);
    in_ch.valid <= 1'b0;

    // Wait for outstanding results, then a margin for anything spurious
    while (board.status_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d items (append %0d, build %0d, insert %0d, extract %0d)",
             board.n_items, board.op_seen[OP_APPEND], board.op_seen[OP_BUILD],
             board.op_seen[OP_INSERT], board.op_seen[OP_EXTRACT]);
    $display("%0d results checked; store peaked at %0d of %0d, %0d dropped while full",
             board.n_checked, board.peak_fill, CAPACITY, board.n_dropped);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
